[rtl/tgcs_pkg.sv]
// Shared constants and control types for the text grid cursor scroller.
// No dependencies; the top level, sequencer and datapath import this package.
package tgcs_pkg;

    localparam int ROWS   = 22;
    localparam int COLS   = 76;
    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(CELLS);

    // Opcodes of a request word
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;

    typedef struct packed {
        logic capture;     // latch the request word
        logic execute;     // apply the operation to cursor, rows and store
        logic sweep_step;  // blank one cell of the cursor row
        logic load_out;    // move the result into the response register
    } tgcs_cmd_t;

    typedef struct packed {
        logic need_sweep;  // printable put into a row that is not yet blanked
        logic sweep_last;  // sweep is at the last column
        logic out_free;    // response register can take a result
    } tgcs_stat_t;

endpackage

[rtl/tgcs_req_if.sv]
// Request channel: valid/ready handshake with one operation word.
// Depends on nothing.
interface tgcs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_in;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, output opcode, output char_in, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input opcode, input char_in, input read_row,
                    input read_col, output ready);
endinterface

[rtl/tgcs_rsp_if.sv]
// Response channel: valid/ready handshake with one result word.
// Depends on nothing.
interface tgcs_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_value;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic       did_scroll;

    modport source (output valid, output cell_value, output cursor_row_out,
                    output cursor_col_out, output did_scroll, input ready);
    modport sink   (input valid, input cell_value, input cursor_row_out,
                    input cursor_col_out, input did_scroll, output ready);
endinterface

[rtl/text_grid_cursor_scroller.sv]
// Top level of the text grid cursor scroller: joins sequencer and datapath.
// Depends on tgcs_pkg, tgcs_req_if, tgcs_rsp_if, tgcs_ctrl, tgcs_datapath.
//
// A 22 x 76 character-cell screen with a cursor. Each request word (put, read or
// clear) yields exactly one response word holding the read byte, the cursor after
// the operation and a scroll flag. Rows are kept in a circular buffer with one
// blank flag per row, so scroll and clear write no cells and reset needs no
// clearing pass. Most words go through three steps: accept, execute and result
// register. A printable put into a row that has been blanked since the last
// write to it first sweeps zeros across all 76 cells of that row through the
// single write port of the cell store and then decodes the word again. The
// response register lets the next word be accepted while the previous response
// waits to be taken.
module text_grid_cursor_scroller (
    input  logic       clk,
    input  logic       rst_n,
    tgcs_req_if.sink   req,
    tgcs_rsp_if.source rsp
);
    import tgcs_pkg::*;

    tgcs_cmd_t  cmd;
    tgcs_stat_t stat;

    tgcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tgcs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .opcode   (req.opcode),
        .char_in  (req.char_in),
        .read_row (req.read_row),
        .read_col (req.read_col),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp)
    );

endmodule

[rtl/tgcs_ctrl.sv]
// Sequencer for the text grid cursor scroller: accept, row blank sweep,
// execute and result hand-off. Depends on tgcs_pkg.
module tgcs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tgcs_pkg::tgcs_stat_t stat,
    output tgcs_pkg::tgcs_cmd_t  cmd
);
    import tgcs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.need_sweep)
                    state_next = ST_SWEEP;
                else
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                // row is marked blank on the last step; decode again to execute
                if (stat.sweep_last)
                    state_next = ST_DECODE;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/tgcs_datapath.sv]
// Datapath: cursor, circular row pointer, row blank flags, cell store
// and response register. Depends on tgcs_pkg and tgcs_rsp_if.
module tgcs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           opcode,
    input  logic [7:0]           char_in,
    input  logic [4:0]           read_row,
    input  logic [6:0]           read_col,
    input  tgcs_pkg::tgcs_cmd_t  cmd,
    output tgcs_pkg::tgcs_stat_t stat,
    tgcs_rsp_if.source           rsp
);
    import tgcs_pkg::*;

    // captured request word
    logic [1:0]       op_reg;
    logic [7:0]       ch_reg;
    logic [4:0]       rr_reg;
    logic [6:0]       rc_reg;

    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] top_reg, top_next;
    logic [ROWS-1:0]  row_valid_reg, row_valid_next;
    logic [COL_W-1:0] sweep_cnt_reg;
    logic             scroll_reg, scroll_next;
    logic             rd_ok_reg;
    logic [7:0]       rd_q_reg;
    logic             out_valid_reg;
    logic [7:0]       out_cell_reg;
    logic [4:0]       out_row_reg;
    logic [6:0]       out_col_reg;
    logic             out_scroll_reg;

    logic [7:0]       cells [CELLS];
    logic             we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]       wdata;

    logic [ROW_W-1:0] cur_prow;
    logic [ROW_W-1:0] rd_prow;
    logic             rd_in_range;
    logic             printable;
    logic             sweep_last;
    logic [COL_W:0]   col_inc;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] r);
        logic [ROW_W:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= (ROW_W+1)'(ROWS))
            s = s - (ROW_W+1)'(ROWS);
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

    assign cur_prow    = phys_row(top_reg, cur_row_reg);
    assign rd_prow     = phys_row(top_reg, ROW_W'(rr_reg));
    assign rd_in_range = (int'(rr_reg) < ROWS) && (int'(rc_reg) < COLS);
    assign printable   = (ch_reg != CH_NEWLINE) && (ch_reg != CH_RETURN)
                         && (ch_reg != CH_BACKSPACE);
    assign sweep_last  = (sweep_cnt_reg == COL_W'(COLS - 1));
    assign col_inc     = (COL_W+1)'(cur_col_reg) + (COL_W+1)'(1);

    assign stat.need_sweep = (op_reg == OP_PUT) && printable && !row_valid_reg[cur_prow];
    assign stat.sweep_last = sweep_last;
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= opcode;
            ch_reg <= char_in;
            rr_reg <= read_row;
            rc_reg <= read_col;
        end
    end

    // row sweep, operation decode and cursor movement
    always_comb
    begin
        logic go_nl;
        go_nl          = 1'b0;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        scroll_next    = 1'b0;
        we             = 1'b0;
        waddr          = cell_addr(cur_prow, sweep_cnt_reg);
        wdata          = 8'd0;

        if (cmd.sweep_step)
        begin
            we = 1'b1;
            if (sweep_last)
                row_valid_next[cur_prow] = 1'b1;
        end
        else if (cmd.execute)
        begin
            unique case (op_reg)
                OP_PUT:
                begin
                    priority if (ch_reg == CH_NEWLINE)
                        go_nl = 1'b1;
                    else if (ch_reg == CH_RETURN)
                        cur_col_next = '0;
                    else if (ch_reg == CH_BACKSPACE)
                    begin
                        if (cur_col_reg != '0)
                        begin
                            cur_col_next = cur_col_reg - COL_W'(1);
                            // a blank row already reads as empty
                            we    = row_valid_reg[cur_prow];
                            waddr = cell_addr(cur_prow, cur_col_reg - COL_W'(1));
                        end
                    end
                    else
                    begin
                        we    = 1'b1;
                        waddr = cell_addr(cur_prow, cur_col_reg);
                        wdata = ch_reg;
                        if (col_inc >= (COL_W+1)'(COLS))
                            go_nl = 1'b1;
                        else
                            cur_col_next = col_inc[COL_W-1:0];
                    end
                end
                OP_CLEAR:
                begin
                    row_valid_next = '0;
                    top_next       = '0;
                    cur_row_next   = '0;
                    cur_col_next   = '0;
                end
                default:
                begin
                end
            endcase

            if (go_nl)
            begin
                cur_col_next = '0;
                if (cur_row_reg == ROW_W'(ROWS - 1))
                begin
                    // old top row becomes the new bottom row, blanked by its flag
                    scroll_next             = 1'b1;
                    row_valid_next[top_reg] = 1'b0;
                    top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + ROW_W'(1);
                end
                else
                    cur_row_next = cur_row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            if (cmd.sweep_step)
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + COL_W'(1);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            cells[waddr] <= wdata;
        if (cmd.execute && (op_reg == OP_READ) && rd_in_range)
            rd_q_reg <= cells[cell_addr(rd_prow, COL_W'(rc_reg))];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            scroll_reg <= scroll_next;
            rd_ok_reg  <= (op_reg == OP_READ) && rd_in_range && row_valid_reg[rd_prow];
        end
        if (cmd.load_out)
        begin
            out_cell_reg   <= rd_ok_reg ? rd_q_reg : 8'd0;
            out_row_reg    <= 5'(cur_row_reg);
            out_col_reg    <= 7'(cur_col_reg);
            out_scroll_reg <= scroll_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.cell_value     = out_cell_reg;
    assign rsp.cursor_row_out = out_row_reg;
    assign rsp.cursor_col_out = out_col_reg;
    assign rsp.did_scroll     = out_scroll_reg;

    a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_row_reg) < ROWS) && (int'(cur_col_reg) < COLS))
        else $error("cursor left the grid");

    a_no_exec_mid_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> (sweep_cnt_reg == '0))
        else $error("operation executed during a row sweep");

    a_put_to_blanked_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && (op_reg == OP_PUT) && printable) |-> row_valid_reg[cur_prow])
        else $error("character written into a row that was not blanked");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp.ready))
        else $error("result overwrote a response not yet taken");

endmodule
